// File: rtl/lpd_pkg.sv
// Shared widths and the result item type of the length-prefix deframer.
`default_nettype none

package lpd_pkg;

   localparam int BYTE_W = 8;
   localparam int CSR_W  = 32;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              frame_last;
      logic              frame_empty;
      logic              too_long;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/lpd_parse.sv
// Header collection, payload counting and per-byte result decode.
`default_nettype none

module lpd_parse #(
   parameter int HEADER_BYTES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [lpd_pkg::BYTE_W-1:0]  in_byte,
   input  logic                        csr_write,
   input  logic [lpd_pkg::CSR_W-1:0]   csr_max_length,
   output logic                        res_emit,
   output lpd_pkg::rsp_type            res
);
   import lpd_pkg::*;

   localparam int LEN_W = BYTE_W * HEADER_BYTES;
   localparam int IDX_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam int CMP_W = (LEN_W > CSR_W) ? LEN_W : CSR_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HEADER_BYTES - 1);

   typedef enum logic [2:0] {
      ST_HEADER = 3'b001,
      ST_PASS   = 3'b010,
      ST_DROP   = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [LEN_W-1:0]   header_ff, header_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic [CSR_W-1:0]   max_length_ff, max_length_in;

   logic [LEN_W-1:0]   hdr_base;
   logic               last_byte;
   logic               hdr_done;
   logic               hdr_zero;
   logic               hdr_over;

   always_comb begin
      hdr_base  = (idx_ff == '0) ? '0 : header_ff;
      header_in = hdr_base;
      for (int k = 0; k < HEADER_BYTES; k++) begin
         if (idx_ff == IDX_W'(k)) begin
            header_in[BYTE_W*k +: BYTE_W] = hdr_base[BYTE_W*k +: BYTE_W] | in_byte;
         end
      end
   end

   assign last_byte = (left_ff <= LEN_W'(1));
   assign hdr_done  = (idx_ff >= LAST_IDX);
   assign hdr_zero  = (header_in == '0);
   assign hdr_over  = (CMP_W'(header_in) > CMP_W'(max_length_ff));

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      max_length_in = csr_write ? csr_max_length : max_length_ff;
      res_emit      = 1'b0;
      res           = '0;
      if (accept) begin
         unique case (state_ff)
            ST_HEADER: begin
               if (!hdr_done) begin
                  idx_in = idx_ff + IDX_W'(1);
               end else begin
                  idx_in  = '0;
                  left_in = header_in;
                  if (hdr_zero) begin
                     res_emit        = 1'b1;
                     res.frame_last  = 1'b1;
                     res.frame_empty = 1'b1;
                  end else if (hdr_over) begin
                     state_in     = ST_DROP;
                     res_emit     = 1'b1;
                     res.frame_last = 1'b1;
                     res.too_long = 1'b1;
                  end else begin
                     state_in = ST_PASS;
                  end
               end
            end
            ST_PASS: begin
               res_emit       = 1'b1;
               res.out_byte   = in_byte;
               res.frame_last = last_byte;
               left_in        = last_byte ? '0 : left_ff - LEN_W'(1);
               if (last_byte) begin
                  state_in = ST_HEADER;
               end
            end
            ST_DROP: begin
               left_in = last_byte ? '0 : left_ff - LEN_W'(1);
               if (last_byte) begin
                  state_in = ST_HEADER;
               end
            end
            default: begin
               state_in = ST_HEADER;
               idx_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_HEADER;
         idx_ff        <= '0;
         max_length_ff <= '1;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         max_length_ff <= max_length_in;
      end
   end

   always_ff @(posedge clock) begin
      header_ff <= accept ? header_in : header_ff;
      left_ff   <= left_in;
   end

endmodule

`default_nettype wire

// File: rtl/lpd_out.sv
// Result register with downstream backpressure.
`default_nettype none

module lpd_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  lpd_pkg::rsp_type   load_data,
   output logic               pipe_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output lpd_pkg::rsp_type   rsp_data
);
   import lpd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign pipe_ready = !valid_ff || rsp_ready;
   assign valid_in   = pipe_ready ? load : valid_ff;
   assign data_in    = (pipe_ready && load) ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/length_prefix_deframer.sv
// Top level of the length-prefix deframer.
// A result item is registered and appears in the cycle after its input byte.
// Throughput: one byte per cycle; a held result stalls the input only while
// rsp_ready is low. Header bytes give no item but the last of an empty or
// too-long frame; dropped payload gives none. Reset (synchronous): back to
// header collection, no result pending, max_length set to all ones.
`default_nettype none

module length_prefix_deframer #(
   parameter int HEADER_BYTES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lpd_pkg::BYTE_W-1:0]  req_in_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lpd_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_frame_last,
   output logic                        rsp_frame_empty,
   output logic                        rsp_too_long,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lpd_pkg::CSR_W-1:0]   csr_max_length
);
   import lpd_pkg::*;

   logic    accept;
   logic    res_emit;
   logic    pipe_ready;
   rsp_type res;
   rsp_type rsp_data;

   assign req_ready = pipe_ready;
   assign accept    = req_valid && pipe_ready;
   assign csr_ready = 1'b1;

   lpd_parse #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_parse (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .in_byte        (req_in_byte),
      .csr_write      (csr_valid),
      .csr_max_length (csr_max_length),
      .res_emit       (res_emit),
      .res            (res)
   );

   lpd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_emit),
      .load_data  (res),
      .pipe_ready (pipe_ready),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   assign rsp_out_byte    = rsp_data.out_byte;
   assign rsp_frame_last  = rsp_data.frame_last;
   assign rsp_frame_empty = rsp_data.frame_empty;
   assign rsp_too_long    = rsp_data.too_long;

endmodule

`default_nettype wire

// File: rtl/lpd_check.sv
// Port-level checks on the length-prefix deframer, bound to the top level.
`default_nettype none

module lpd_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [lpd_pkg::BYTE_W-1:0]  rsp_out_byte,
   input logic                        rsp_frame_last,
   input logic                        rsp_frame_empty,
   input logic                        rsp_too_long
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_frame_last) && $stable(rsp_frame_empty) && $stable(rsp_too_long))
      else $error("result item changed while stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while result register is full");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_empty |-> rsp_frame_last && !rsp_too_long
         && rsp_out_byte == '0)
      else $error("malformed empty-frame item");

   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_frame_last && !rsp_frame_empty
         && rsp_out_byte == '0)
      else $error("malformed too-long item");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind length_prefix_deframer lpd_check u_check (.*);

`default_nettype wire

// File: verif/tb_length_prefix_deframer.sv
// Self-checking testbench for length_prefix_deframer: directed frames, random streams, huge length.
`default_nettype none

module tb_length_prefix_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import lpd_pkg::*;

   localparam int HDR_BYTES = 8;
   localparam int PHASE_ITEMS = 232;

   localparam rsp_type NO_RSP = '0;
   localparam rsp_type EMPTY_FRAME = '{out_byte: 8'h00, frame_last: 1'b1,
                                       frame_empty: 1'b1, too_long: 1'b0};
   localparam rsp_type OVERSIZE = '{out_byte: 8'h00, frame_last: 1'b1,
                                    frame_empty: 1'b0, too_long: 1'b1};
   localparam rsp_type LAST_FF = '{out_byte: 8'hFF, frame_last: 1'b1,
                                   frame_empty: 1'b0, too_long: 1'b0};

   typedef struct {
      bit               set_limit;
      logic [CSR_W-1:0] limit;
      logic [BYTE_W-1:0] b;
      bit               pin;
      rsp_type          want;
   } step_row;

   step_row steps [0:25] = '{
      '{0, 0, 8'h00, 0, NO_RSP}, '{0, 0, 8'h00, 0, NO_RSP},
      '{0, 0, 8'h00, 0, NO_RSP}, '{0, 0, 8'h00, 0, NO_RSP},
      '{0, 0, 8'h00, 0, NO_RSP}, '{0, 0, 8'h00, 0, NO_RSP},
      '{0, 0, 8'h00, 0, NO_RSP}, '{0, 0, 8'h00, 1, EMPTY_FRAME},
      '{0, 0, 8'h01, 0, NO_RSP}, '{0, 0, 8'h00, 0, NO_RSP},
      '{0, 0, 8'h00, 0, NO_RSP}, '{0, 0, 8'h00, 0, NO_RSP},
      '{0, 0, 8'h00, 0, NO_RSP}, '{0, 0, 8'h00, 0, NO_RSP},
      '{0, 0, 8'h00, 0, NO_RSP}, '{0, 0, 8'h00, 0, NO_RSP},
      '{0, 0, 8'hFF, 1, LAST_FF},
      '{1, 0, 8'h01, 0, NO_RSP}, '{0, 0, 8'h00, 0, NO_RSP},
      '{0, 0, 8'h00, 0, NO_RSP}, '{0, 0, 8'h00, 0, NO_RSP},
      '{0, 0, 8'h00, 0, NO_RSP}, '{0, 0, 8'h00, 0, NO_RSP},
      '{0, 0, 8'h00, 0, NO_RSP}, '{0, 0, 8'h00, 1, OVERSIZE},
      '{0, 0, 8'h5A, 0, NO_RSP}
   };

   int unsigned send_idle_pcts [4] = '{0, 65, 0, 9};
   int unsigned stall_pcts [4] = '{0, 0, 65, 9};
   logic [CSR_W-1:0] phase_limits [4] = '{32'd12, 32'd0, 32'hFFFF_FFFF, 32'd3};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_in_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_frame_last;
   logic              rsp_frame_empty;
   logic              rsp_too_long;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_max_length = '0;

   // travels with each item: a hand-written result the item must produce
   bit      req_pin = 1'b0;
   rsp_type req_want = NO_RSP;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned mismatches = 0;

   rsp_type          frame_results_q [$];
   logic [BYTE_W-1:0] stream_q [$];

   // deframer state mirror
   bit               in_body;
   bit               discarding;
   int unsigned      hdr_pos;
   logic [63:0]      hdr_len;
   logic [63:0]      body_left;
   logic [CSR_W-1:0] len_limit;

   length_prefix_deframer #(.HEADER_BYTES(HDR_BYTES)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_last (rsp_frame_last),
      .rsp_frame_empty(rsp_frame_empty),
      .rsp_too_long   (rsp_too_long),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_length (csr_max_length)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output rsp_type r);
      bit fin;
      int unsigned pos;
      r = NO_RSP;
      if (in_body) begin
         fin = (body_left <= 64'd1);
         if (body_left != 64'd0) body_left = body_left - 64'd1;
         if (fin) begin
            in_body = 1'b0;
            body_left = '0;
         end
         if (discarding) begin
            if (fin) discarding = 1'b0;
            return 1'b0;
         end
         r.out_byte = b;
         r.frame_last = fin;
         return 1'b1;
      end
      pos = hdr_pos;
      if (pos == 0) hdr_len = '0;
      hdr_len = hdr_len | (64'(b) << (8 * pos));
      if (pos + 1 < HDR_BYTES) begin
         hdr_pos = pos + 1;
         return 1'b0;
      end
      hdr_pos = 0;
      if (hdr_len == 64'd0) begin
         r = EMPTY_FRAME;
         return 1'b1;
      end
      in_body = 1'b1;
      body_left = hdr_len;
      if (hdr_len > {32'd0, len_limit}) begin
         discarding = 1'b1;
         r = OVERSIZE;
         return 1'b1;
      end
      discarding = 1'b0;
      return 1'b0;
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      rsp_type pred;
      bit made;
      if (reset) begin
         in_body = 1'b0;
         discarding = 1'b0;
         hdr_pos = 0;
         hdr_len = '0;
         body_left = '0;
         len_limit = 32'hFFFF_FFFF;
      end else begin
         if (csr_valid && csr_ready) len_limit = csr_max_length;
         if (req_valid && req_ready) begin
            made = deframe_byte(req_in_byte, pred);
            if (made) frame_results_q.push_back(pred);
            if (req_pin && (!made || pred !== req_want)) begin
               $display("%0t: directed item mismatch, expected %0h, predicted %0h (made %0b)",
                        $time, req_want, pred, made);
               mismatches++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{out_byte: rsp_out_byte, frame_last: rsp_frame_last,
                    frame_empty: rsp_frame_empty, too_long: rsp_too_long};
            if (frame_results_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, got %0h", $time, got);
               mismatches++;
            end else begin
               want = frame_results_q.pop_front();
               compare_field("out_byte", want.out_byte, got.out_byte);
               compare_field("frame_last", 8'(want.frame_last), 8'(got.frame_last));
               compare_field("frame_empty", 8'(want.frame_empty), 8'(got.frame_empty));
               compare_field("too_long", 8'(want.too_long), 8'(got.too_long));
            end
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit pin, input rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_pin <= pin;
      req_want <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_W-1:0] v);
      csr_valid <= 1'b1;
      csr_max_length <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_frame();
      int unsigned pick;
      logic [63:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 10) len = '0;
      else if (pick < 85) len = 64'($urandom_range(1, 16));
      else len = 64'($urandom_range(17, 40));
      for (int i = 0; i < HDR_BYTES; i++) stream_q.push_back(len[8*i +: 8]);
      for (int i = 0; i < len; i++) stream_q.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin
      logic [63:0] huge;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i]) begin
         if (steps[i].set_limit) begin
            settle();
            write_limit(steps[i].limit);
         end
         send_byte(steps[i].b, steps[i].pin, steps[i].want);
      end

      // phase boundaries may fall anywhere inside a frame
      for (int p = 0; p < 4; p++) begin
         settle();
         write_limit(phase_limits[p]);
         send_idle_pct = send_idle_pcts[p];
         stall_pct = stall_pcts[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (stream_q.size() == 0) queue_frame();
            send_byte(stream_q.pop_front(), 1'b0, NO_RSP);
         end
      end
      while (stream_q.size() != 0) send_byte(stream_q.pop_front(), 1'b0, NO_RSP);

      // length beyond 32 bits: flagged, and the payload would never finish
      settle();
      write_limit(32'hFFFF_FFFF);
      huge = {$urandom(), $urandom()};
      huge[56] = 1'b1;
      for (int i = 0; i < HDR_BYTES; i++)
         send_byte(huge[8*i +: 8], (i == HDR_BYTES - 1), OVERSIZE);
      settle();

      if (mismatches == 0) begin
         $display("length_prefix_deframer test passed");
      end else begin
         $display("length_prefix_deframer test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("length_prefix_deframer test failed");
      $finish;
   end

endmodule

`default_nettype wire
